/* sv/debug_packet_receiver_checksum_macros.svh */
// Assertion helpers for the RTL file that checks its own behavior.
`ifndef DEBUG_PACKET_RECEIVER_CHECKSUM_MACROS_SVH
`define DEBUG_PACKET_RECEIVER_CHECKSUM_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DPR_ASSERT_NOW(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("DPR assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is high.
`define DPR_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("DPR assertion failed: next-cycle check");

`endif

/* sv/dpr_pkg.sv */
package dpr_pkg;

  localparam int CharWidth   = 8;
  localparam int LenWidth    = 16;
  localparam int DigitWidth  = 4;

  localparam logic [CharWidth-1:0] CH_START = 8'h24;
  localparam logic [CharWidth-1:0] CH_END   = 8'h23;
  localparam logic [CharWidth-1:0] CH_ACK   = 8'h2B;
  localparam logic [CharWidth-1:0] CH_NAK   = 8'h2D;

  localparam logic [LenWidth-1:0] MAX_LEN_RESET = 16'd4096;
  localparam logic [LenWidth-1:0] LEN_SAT       = 16'hFFFF;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Receiver phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_LOW  = 2'd3;

  typedef struct packed {
    logic                 kind;
    logic [CharWidth-1:0] ch;
    logic                 good;
    logic                 oversize;
    logic [LenWidth-1:0]  length;
  } res_t;

  // Hex digit value of a character; anything that is not a hex digit is 0.
  function automatic logic [DigitWidth-1:0] hex_value(input logic [CharWidth-1:0] c);
    logic [CharWidth-1:0] v;
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    return v[DigitWidth-1:0];
  endfunction

endpackage

/* sv/dpr_parser.sv */
module dpr_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [dpr_pkg::CharWidth-1:0] ch,
  input  logic [dpr_pkg::LenWidth-1:0]  max_len,
  output logic                          produce,
  output dpr_pkg::res_t                 res
);
  import dpr_pkg::*;

  logic [1:0]            phase, phase_next;
  logic [CharWidth-1:0]  running_sum, running_sum_next;
  logic [LenWidth-1:0]   char_count, char_count_next;
  logic [DigitWidth-1:0] high_digit, high_digit_next;
  logic                  too_long, too_long_next;
  logic [LenWidth:0]     count_inc;
  logic [CharWidth-1:0]  sent_sum;
  logic                  good;

  assign count_inc = {1'b0, char_count} + {{LenWidth{1'b0}}, 1'b1};
  assign sent_sum  = {high_digit, hex_value(ch)};
  assign good      = (sent_sum == running_sum) && !too_long;

  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    char_count_next  = char_count;
    high_digit_next  = high_digit;
    too_long_next    = too_long;
    produce          = 1'b0;
    res              = '0;
    case (phase)
      PH_IDLE: begin
        if (ch == CH_START) begin
          running_sum_next = '0;
          char_count_next  = '0;
          too_long_next    = 1'b0;
          phase_next       = PH_BODY;
        end
      end
      PH_BODY: begin
        if (ch == CH_END) begin
          phase_next = PH_HIGH;
        end else begin
          running_sum_next = running_sum + ch;
          if (count_inc > {1'b0, max_len}) begin
            too_long_next = 1'b1;
          end
          char_count_next = count_inc[LenWidth] ? LEN_SAT : count_inc[LenWidth-1:0];
          produce         = 1'b1;
          res.kind        = KIND_PAYLOAD;
          res.ch          = ch;
        end
      end
      PH_HIGH: begin
        high_digit_next = hex_value(ch);
        phase_next      = PH_LOW;
      end
      PH_LOW: begin
        produce      = 1'b1;
        res.kind     = KIND_VERDICT;
        res.ch       = good ? CH_ACK : CH_NAK;
        res.good     = good;
        res.oversize = too_long;
        res.length   = char_count;
        phase_next   = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      running_sum <= '0;
      char_count  <= '0;
      high_digit  <= '0;
      too_long    <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      char_count  <= char_count_next;
      high_digit  <= high_digit_next;
      too_long    <= too_long_next;
    end
  end

endmodule

/* sv/dpr_out_reg.sv */
module dpr_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          produce,
  input  dpr_pkg::res_t                 res,
  output logic                          can_load,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [dpr_pkg::CharWidth-1:0] out_char,
  output logic                          packet_good,
  output logic                          oversize,
  output logic [dpr_pkg::LenWidth-1:0]  payload_length
);
  import dpr_pkg::*;

  res_t held;

  // A new result may enter when the register is empty or is being emptied now.
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= produce;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && produce) begin
      held <= res;
    end
  end

  assign result_kind    = held.kind;
  assign out_char       = held.ch;
  assign packet_good    = held.good;
  assign oversize       = held.oversize;
  assign payload_length = held.length;

endmodule

/* sv/debug_packet_receiver_checksum.sv */
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   rx_char
// result    out        out_valid / out_ready result_kind, out_char, packet_good, oversize,
//                                            payload_length
// config    in         cfg_valid / cfg_ready cfg_data (max_payload_length)
//
// One character request is taken every cycle unless the result side stalls.
// The rate is set by the input register feeding the parser step and the result register.
// Reset is synchronous and active high; it restores the wait for '$' and a limit of 4096.
// A stall on the result side holds both registers once full; in_ready drops the same cycle.
// The configuration port is always ready; each accepted write loads the limit.
module debug_packet_receiver_checksum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dpr_pkg::CharWidth-1:0] rx_char,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [dpr_pkg::CharWidth-1:0] out_char,
  output logic                          packet_good,
  output logic                          oversize,
  output logic [dpr_pkg::LenWidth-1:0]  payload_length,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dpr_pkg::LenWidth-1:0]  cfg_data
);
  import dpr_pkg::*;
  `include "debug_packet_receiver_checksum_macros.svh"

  // The limit register accepts a write in any cycle.
  logic [LenWidth-1:0]  max_len;
  // Input register: one received character waiting for the parser step.
  logic                 in_held;
  logic [CharWidth-1:0] in_char;
  logic                 can_load;
  logic                 advance;
  logic                 produce;
  res_t                 res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= cfg_data;
    end
  end

  // The held character steps the parser when the result register can take its result.
  // Characters that cause no result step as well, they only leave the result register alone.
  assign advance  = in_held && can_load;
  assign in_ready = !in_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char <= rx_char;
    end
  end

  dpr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .ch      (in_char),
    .max_len (max_len),
    .produce (produce),
    .res     (res)
  );

  dpr_out_reg u_out_reg (
    .clk            (clk),
    .rst            (rst),
    .load           (advance),
    .produce        (produce),
    .res            (res),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .out_char       (out_char),
    .packet_good    (packet_good),
    .oversize       (oversize),
    .payload_length (payload_length)
  );

  // With an empty result register the block must never refuse a character.
  `DPR_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  // An accepted character lands in the input register.
  `DPR_ASSERT_NEXT(a_accept_held, clk, rst, in_valid && in_ready, in_held)
  // Payload results carry no verdict information.
  `DPR_ASSERT_NOW(a_payload_clean, clk, rst, out_valid && (result_kind == KIND_PAYLOAD),
    !packet_good && !oversize && (payload_length == '0))

endmodule
